[rtl/fbpa_pkg.sv]
// Shared types, widths and codes of the fixed block pool allocator.
package fbpa_pkg;

    localparam int OFFSET_W   = 21;
    localparam int PAYLOAD_W  = 13;
    localparam int COUNT_W    = 9;
    localparam int ERR_W      = 3;
    localparam int STRIDE_W   = 14;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 16;

    // The divider retires two quotient bits per step over a padded dividend.
    localparam int DIV_STEPS  = (OFFSET_W + 1) / 2;
    localparam int QUOT_W     = 2 * DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [PAYLOAD_W-1:0] RESET_PAYLOAD = PAYLOAD_W'(60);
    localparam int                   RESET_COUNT   = 256;

    localparam logic [CFG_ADDR_W-1:0] REG_PAYLOAD = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_COUNT   = CFG_ADDR_W'(1);

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } t_kind;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 3'd0,
        ERR_EMPTY     = 3'd1,
        ERR_MISALIGN  = 3'd2,
        ERR_RANGE     = 3'd3,
        ERR_NOT_ALLOC = 3'd4
    } t_err;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ARD,
        S_AMUL,
        S_DIV,
        S_FRD,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [STRIDE_W-1:0] stride;
        logic [STRIDE_W+1:0] stride3;
        logic [COUNT_W-1:0]  count;
        logic                busy;
        logic                rebuild;
    } t_pool_cfg;

    typedef struct packed {
        logic                start;
        logic [OFFSET_W-1:0] node;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              rem_zero;
        logic [QUOT_W-1:0] quot;
    } t_div_res;

    typedef struct packed {
        logic                ok;
        t_err                error;
        logic [OFFSET_W-1:0] alloc_offset;
        logic [COUNT_W-1:0]  in_use;
    } t_rsp;

endpackage

[rtl/fbpa_if.sv]
// Handshake interfaces for the request, response and configuration channels.
interface fbpa_req_if import fbpa_pkg::*; ();
    logic                valid;
    logic                ready;
    t_kind               kind;
    logic [OFFSET_W-1:0] user_offset;

    modport source (output valid, output kind, output user_offset, input ready);
    modport sink   (input valid, input kind, input user_offset, output ready);
endinterface

interface fbpa_rsp_if import fbpa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                ok;
    t_err                error;
    logic [OFFSET_W-1:0] alloc_offset;
    logic [COUNT_W-1:0]  in_use;

    modport source (output valid, output ok, output error, output alloc_offset,
                    output in_use, input ready);
    modport sink   (input valid, input ok, input error, input alloc_offset,
                    input in_use, output ready);
endinterface

interface fbpa_cfg_if import fbpa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

[rtl/fixed_block_pool_allocator.sv]
// Top level of the fixed block pool allocator.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+--------------------------------------
//  i_cfg    | in  | valid/ready   | addr (register index), data
//  i_req    | in  | valid/ready   | kind, user_offset
//  o_rsp    | out | valid/ready   | ok, error, alloc_offset, in_use
//
// An allocate takes one link memory read, the write-back, and the stride
// multiply for the offset before its result is loaded. A head block still
// unused since the last rebuild skips the read. A successful free runs the
// radix-4 divider that turns the offset into a block index, then one
// read-modify-write of the mark and link memory. A free rejected on the divider
// result skips the read-modify-write, and one below the header is answered
// without the divider. The next item can be accepted in the cycle after a
// result is loaded, unless a payload write still holds i_req.ready low.
// Reset and configuration writes need no clearing pass: a fill count tells
// never-used blocks apart. A payload write holds i_req.ready low while the
// stride is recomputed. A stalled result sits in the output register
// while the next item is accepted and worked on.
module fixed_block_pool_allocator import fbpa_pkg::*; #(
    parameter int MAX_BLOCKS   = 256,
    parameter int HEADER_BYTES = 4,
    parameter int ALIGN_BYTES  = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fbpa_cfg_if.sink    i_cfg,
    fbpa_req_if.sink    i_req,
    fbpa_rsp_if.source  o_rsp
);

    t_pool_cfg pool;
    t_div_req  div_req;
    t_div_res  div_res;

    fbpa_cfg #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES),
        .ALIGN_BYTES  (ALIGN_BYTES)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_pool  (pool)
    );

    fbpa_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (div_req),
        .i_stride  (pool.stride),
        .i_stride3 (pool.stride3),
        .o_res     (div_res)
    );

    fbpa_list #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_pool  (pool),
        .o_div   (div_req),
        .i_div   (div_res)
    );

endmodule

[rtl/fbpa_cfg.sv]
// Configuration registers and the block stride computation.
module fbpa_cfg import fbpa_pkg::*; #(
    parameter int MAX_BLOCKS   = 256,
    parameter int HEADER_BYTES = 4,
    parameter int ALIGN_BYTES  = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fbpa_cfg_if.sink  i_cfg,
    output t_pool_cfg o_pool
);

    localparam int MAX_COUNT = (1 << COUNT_W) - 1;
    localparam int CAP       = (MAX_BLOCKS > MAX_COUNT) ? MAX_COUNT : MAX_BLOCKS;
    localparam int RST_CNT   = (RESET_COUNT > CAP) ? CAP : RESET_COUNT;

    // Ceiling reciprocal of the alignment. With STRIDE_W + 7 fraction bits the
    // truncated product equals the exact quotient for every 14-bit numerator.
    localparam int          SH      = STRIDE_W + 7;
    localparam int          RECIP_W = SH + 1;
    localparam int unsigned RECIP   = ((1 << SH) + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int          PROD_W  = STRIDE_W + RECIP_W;

    logic [PAYLOAD_W-1:0] r_payload;
    logic [COUNT_W-1:0]   r_count;
    logic [1:0]           r_settle;
    logic [STRIDE_W-1:0]  r_q;
    logic [STRIDE_W-1:0]  r_stride;
    logic [STRIDE_W+1:0]  r_stride3;

    logic                 wr_payload;
    logic                 wr_count;
    logic [COUNT_W-1:0]   wr_cnt_val;
    logic [STRIDE_W-1:0]  raw_up;
    logic [PROD_W-1:0]    prod;

    assign i_cfg.ready = 1'b1;
    assign wr_payload  = i_cfg.valid && (i_cfg.addr == REG_PAYLOAD);
    assign wr_count    = i_cfg.valid && (i_cfg.addr == REG_COUNT);
    assign wr_cnt_val  = (i_cfg.data[COUNT_W-1:0] > COUNT_W'(CAP)) ? COUNT_W'(CAP)
                                                                  : i_cfg.data[COUNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload <= RESET_PAYLOAD;
            r_count   <= COUNT_W'(RST_CNT);
            r_settle  <= 2'd2;
        end else begin
            if (wr_payload) begin
                r_payload <= i_cfg.data[PAYLOAD_W-1:0];
            end
            if (wr_count) begin
                r_count <= wr_cnt_val;
            end
            if (wr_payload) begin
                r_settle <= 2'd2;
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
        end
    end

    assign raw_up = STRIDE_W'(r_payload) + STRIDE_W'(HEADER_BYTES + ALIGN_BYTES - 1);
    assign prod   = PROD_W'(raw_up) * PROD_W'(RECIP);

    // Two stages follow the payload register; r_settle covers their latency.
    always_ff @(posedge i_clk) begin
        r_q       <= prod[SH +: STRIDE_W];
        r_stride  <= STRIDE_W'(r_q * ALIGN_BYTES);
        r_stride3 <= (STRIDE_W + 2)'(r_q * (3 * ALIGN_BYTES));
    end

    assign o_pool.stride  = r_stride;
    assign o_pool.stride3 = r_stride3;
    assign o_pool.count   = r_count;
    assign o_pool.busy    = (r_settle != 2'd0);
    assign o_pool.rebuild = wr_payload || wr_count;

endmodule

[rtl/fbpa_div.sv]
// Radix-4 restoring divider: node offset by block stride, two bits per cycle.
module fbpa_div import fbpa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_div_req            i_req,
    input  logic [STRIDE_W-1:0] i_stride,
    input  logic [STRIDE_W+1:0] i_stride3,
    output t_div_res            o_res
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [STRIDE_W-1:0]  r_rem;
    logic [QUOT_W-1:0]    r_dvd;

    logic [STRIDE_W+1:0]  cur;
    logic [STRIDE_W+1:0]  s1;
    logic [STRIDE_W+1:0]  s2;
    logic [STRIDE_W+1:0]  sub;
    logic [1:0]           digit;

    assign s1  = {2'b00, i_stride};
    assign s2  = {1'b0, i_stride, 1'b0};
    assign cur = {r_rem, r_dvd[QUOT_W-1 -: 2]};

    always_comb begin
        if (cur >= i_stride3) begin
            digit = 2'd3;
            sub   = cur - i_stride3;
        end else if (cur >= s2) begin
            digit = 2'd2;
            sub   = cur - s2;
        end else if (cur >= s1) begin
            digit = 2'd1;
            sub   = cur - s1;
        end else begin
            digit = 2'd0;
            sub   = cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_STEPS);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - DIV_CNT_W'(1);
            r_busy <= (r_cnt != DIV_CNT_W'(1));
        end
    end

    // Quotient bits shift in at the bottom as dividend bits leave the top.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= QUOT_W'(i_req.node);
        end else if (r_busy) begin
            r_rem <= sub[STRIDE_W-1:0];
            r_dvd <= {r_dvd[QUOT_W-3:0], digit};
        end
    end

    assign o_res.busy     = r_busy;
    assign o_res.rem_zero = (r_rem == '0);
    assign o_res.quot     = r_dvd;

endmodule

[rtl/fbpa_list.sv]
// Free list sequencer around the link and allocation-mark memory.
module fbpa_list import fbpa_pkg::*; #(
    parameter int MAX_BLOCKS   = 256,
    parameter int HEADER_BYTES = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fbpa_req_if.sink     i_req,
    fbpa_rsp_if.source   o_rsp,
    input  t_pool_cfg    i_pool,
    output t_div_req     o_div,
    input  t_div_res     i_div
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int XW = (IW > COUNT_W) ? IW : COUNT_W;
    localparam int MW = IW + 1;
    localparam int PW = IW + STRIDE_W;
    localparam int AW = (PW > OFFSET_W) ? PW : OFFSET_W;

    // Each entry holds {allocated mark, free-list successor}.
    logic [MW-1:0] mem [MAX_BLOCKS];
    logic [MW-1:0] r_rdata;

    t_state             r_state, n_state;
    logic [IW-1:0]      r_head, n_head;
    logic [COUNT_W-1:0] r_fill, n_fill;
    logic [COUNT_W-1:0] r_in_use, n_in_use;
    logic [IW-1:0]      r_blk, n_blk;
    t_rsp               r_res, n_res;
    t_rsp               r_out;
    logic               r_out_valid;

    logic               out_load;
    logic               mem_we;
    logic [IW-1:0]      mem_wa;
    logic [MW-1:0]      mem_wd;
    logic               mem_re;
    logic [IW-1:0]      mem_ra;

    logic               full;
    logic               fresh;
    logic [COUNT_W-1:0] fill_p1;
    logic [IW-1:0]      fresh_next;
    logic [AW-1:0]      aoff_sum;
    logic [IW-1:0]      q_idx;

    // Blocks at or above the fill count were never handed out since the last
    // rebuild: their link is the next index and their mark is clear, so the
    // memory needs no clearing pass.
    assign full       = (r_in_use >= i_pool.count);
    assign fresh      = (XW'(r_head) == XW'(r_fill));
    assign fill_p1    = r_fill + COUNT_W'(1);
    assign fresh_next = (fill_p1 < i_pool.count) ? IW'(fill_p1) : '0;
    assign aoff_sum   = AW'(r_blk) * AW'(i_pool.stride) + AW'(HEADER_BYTES);
    assign q_idx      = i_div.quot[IW-1:0];

    assign i_req.ready = (r_state == S_IDLE) && !i_pool.busy;

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_fill     = r_fill;
        n_in_use   = r_in_use;
        n_blk      = r_blk;
        n_res      = r_res;
        out_load   = 1'b0;
        mem_we     = 1'b0;
        mem_wa     = r_blk;
        mem_wd     = {1'b1, r_rdata[IW-1:0]};
        mem_re     = 1'b0;
        mem_ra     = r_head;
        o_div.start = 1'b0;
        o_div.node  = i_req.user_offset - OFFSET_W'(HEADER_BYTES);

        case (r_state)
            S_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    if (i_req.kind == KIND_ALLOC) begin
                        if (full) begin
                            n_res   = '{ok: 1'b0, error: ERR_EMPTY, alloc_offset: '0,
                                        in_use: '0};
                            n_state = S_RESP;
                        end else if (fresh) begin
                            n_blk    = r_head;
                            n_head   = fresh_next;
                            n_fill   = fill_p1;
                            n_in_use = r_in_use + COUNT_W'(1);
                            mem_we   = 1'b1;
                            mem_wa   = r_head;
                            mem_wd   = {1'b1, {IW{1'b0}}};
                            n_state  = S_AMUL;
                        end else begin
                            n_blk   = r_head;
                            mem_re  = 1'b1;
                            mem_ra  = r_head;
                            n_state = S_ARD;
                        end
                    end else begin
                        if (i_req.user_offset < OFFSET_W'(HEADER_BYTES)) begin
                            n_res   = '{ok: 1'b0, error: ERR_MISALIGN, alloc_offset: '0,
                                        in_use: '0};
                            n_state = S_RESP;
                        end else begin
                            o_div.start = 1'b1;
                            n_state     = S_DIV;
                        end
                    end
                end
            end
            S_ARD: begin
                n_head   = r_rdata[IW-1:0];
                n_in_use = r_in_use + COUNT_W'(1);
                mem_we   = 1'b1;
                mem_wa   = r_blk;
                mem_wd   = {1'b1, r_rdata[IW-1:0]};
                n_state  = S_AMUL;
            end
            S_AMUL: begin
                n_res   = '{ok: 1'b1, error: ERR_NONE, alloc_offset: aoff_sum[OFFSET_W-1:0],
                            in_use: '0};
                n_state = S_RESP;
            end
            S_DIV: begin
                if (!i_div.busy) begin
                    if (!i_div.rem_zero) begin
                        n_res   = '{ok: 1'b0, error: ERR_MISALIGN, alloc_offset: '0,
                                    in_use: '0};
                        n_state = S_RESP;
                    end else if (i_div.quot >= QUOT_W'(i_pool.count)) begin
                        n_res   = '{ok: 1'b0, error: ERR_RANGE, alloc_offset: '0,
                                    in_use: '0};
                        n_state = S_RESP;
                    end else if (i_div.quot >= QUOT_W'(r_fill)) begin
                        n_res   = '{ok: 1'b0, error: ERR_NOT_ALLOC, alloc_offset: '0,
                                    in_use: '0};
                        n_state = S_RESP;
                    end else begin
                        n_blk   = q_idx;
                        mem_re  = 1'b1;
                        mem_ra  = q_idx;
                        n_state = S_FRD;
                    end
                end
            end
            S_FRD: begin
                if (!r_rdata[IW]) begin
                    n_res = '{ok: 1'b0, error: ERR_NOT_ALLOC, alloc_offset: '0, in_use: '0};
                end else begin
                    mem_we   = 1'b1;
                    mem_wa   = r_blk;
                    mem_wd   = {1'b0, r_head};
                    n_head   = r_blk;
                    n_in_use = r_in_use - COUNT_W'(1);
                    n_res    = '{ok: 1'b1, error: ERR_NONE, alloc_offset: '0, in_use: '0};
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                // The result waits here while the output register is full and o_rsp.ready is low.
                if (!r_out_valid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_pool.rebuild) begin
            n_head   = '0;
            n_fill   = '0;
            n_in_use = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_in_use    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_fill   <= n_fill;
            r_in_use <= n_in_use;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        r_res <= n_res;
        if (out_load) begin
            r_out <= '{ok: r_res.ok, error: r_res.error, alloc_offset: r_res.alloc_offset,
                       in_use: r_in_use};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= mem[mem_ra];
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.ok           = r_out.ok;
    assign o_rsp.error        = r_out.error;
    assign o_rsp.alloc_offset = r_out.alloc_offset;
    assign o_rsp.in_use       = r_out.in_use;

endmodule

[rtl/fbpa_checker.sv]
// Port-level assertions for the allocator and the bind that attaches them.
module fbpa_checker import fbpa_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_valid,
    input logic                i_req_ready,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input logic                i_rsp_ok,
    input logic [ERR_W-1:0]    i_rsp_error,
    input logic [OFFSET_W-1:0] i_rsp_alloc_offset,
    input logic [COUNT_W-1:0]  i_rsp_in_use
);

    // A successful item carries no error code, and a failed one always does.
    a_ok_matches_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_ok == (i_rsp_error == ERR_NONE)))
        else $error("ok flag and error code disagree");

    // Only a successful allocate reports a nonzero offset.
    a_offset_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_alloc_offset != '0)) |-> i_rsp_ok)
        else $error("offset reported on a failed or free item");

    // One item at a time: the request side closes right after an acceptance.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted while another is in progress");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_ok)
            && $stable(i_rsp_error) && $stable(i_rsp_alloc_offset)
            && $stable(i_rsp_in_use)))
        else $error("stalled response item changed");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_valid        (i_req.valid),
    .i_req_ready        (i_req.ready),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_ok           (o_rsp.ok),
    .i_rsp_error        (o_rsp.error),
    .i_rsp_alloc_offset (o_rsp.alloc_offset),
    .i_rsp_in_use       (o_rsp.in_use)
);

[tb/tb.sv]
// Self-checking testbench for the fixed block pool allocator.
module tb;
    import fbpa_pkg::*;

    localparam int POOL_BLOCKS   = 256;
    localparam int HDR_BYTES     = 4;
    localparam int ALIGN_BYTES   = 4;
    localparam int CLK_HALF      = 2;
    localparam int RANDOM_ITEMS  = 550;
    localparam int PHASE_ITEMS   = 70;
    localparam int NUM_SETTINGS  = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 40;
    localparam int LIMIT_CYCLES  = 500000;
    localparam int MAX_REPORTS   = 10;
    localparam int OFFSET_MAX    = (1 << OFFSET_W) - 1;

    // Indexes past the end of the register list; writes there must change nothing.
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_LO = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_HI = CFG_ADDR_W'(15);

    typedef struct {
        t_kind               kind;
        logic [OFFSET_W-1:0] user_offset;
    } t_req_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fbpa_cfg_if cfg ();
    fbpa_req_if req ();
    fbpa_rsp_if rsp ();

    fixed_block_pool_allocator #(
        .MAX_BLOCKS   (POOL_BLOCKS),
        .HEADER_BYTES (HDR_BYTES),
        .ALIGN_BYTES  (ALIGN_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Shadow of the pool: free list, allocation marks and configuration.
    int unsigned link_next [POOL_BLOCKS];
    bit          block_marked [POOL_BLOCKS];
    int unsigned free_head;
    int unsigned blocks_in_use;
    int unsigned payload_cfg;
    int unsigned count_cfg;

    t_req_item pending_req_q [$];
    t_rsp      expected_rsp_q [$];
    t_rsp      rsp_want;

    int  fail_count;
    int  random_items_sent;
    int  cycle_count;
    int  send_gap_left;
    int  recv_stall_left;
    int  hold_asked;
    int  hold_served;
    int  hold_left;
    bit  no_idle;
    bit  pressure_done;

    function automatic int unsigned pool_eff_count();
        return (count_cfg > POOL_BLOCKS) ? POOL_BLOCKS : count_cfg;
    endfunction

    function automatic int unsigned pool_stride();
        return ((payload_cfg + HDR_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    endfunction

    function automatic void pool_rebuild();
        int unsigned n;
        n = pool_eff_count();
        for (int i = 0; i < POOL_BLOCKS; i++) begin
            link_next[i]    = (i + 1 < n) ? i + 1 : 0;
            block_marked[i] = 1'b0;
        end
        free_head     = 0;
        blocks_in_use = 0;
    endfunction

    function automatic void pool_apply_config(logic [CFG_ADDR_W-1:0] idx,
                                              logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_PAYLOAD: begin
                payload_cfg = value[PAYLOAD_W-1:0];
                pool_rebuild();
            end
            REG_COUNT: begin
                count_cfg = value[COUNT_W-1:0];
                pool_rebuild();
            end
            default: ;
        endcase
    endfunction

    function automatic t_rsp pool_apply_request(t_kind kind, logic [OFFSET_W-1:0] uoff);
        t_rsp        r;
        int unsigned n;
        int unsigned s;
        int unsigned blk;
        int unsigned node;
        n              = pool_eff_count();
        s              = pool_stride();
        r.ok           = 1'b0;
        r.error        = ERR_NONE;
        r.alloc_offset = '0;
        if (kind == KIND_ALLOC) begin
            if (blocks_in_use >= n) begin
                r.error = ERR_EMPTY;
            end else begin
                blk               = free_head;
                free_head         = link_next[blk];
                block_marked[blk] = 1'b1;
                blocks_in_use++;
                r.alloc_offset    = OFFSET_W'(blk * s + HDR_BYTES);
                r.ok              = 1'b1;
            end
        end else if (uoff < HDR_BYTES) begin
            r.error = ERR_MISALIGN;
        end else begin
            node = uoff - HDR_BYTES;
            blk  = node / s;
            if (node % s != 0) begin
                r.error = ERR_MISALIGN;
            end else if (blk >= n) begin
                r.error = ERR_RANGE;
            end else if (!block_marked[blk]) begin
                r.error = ERR_NOT_ALLOC;
            end else begin
                block_marked[blk] = 1'b0;
                link_next[blk]    = free_head;
                free_head         = blk;
                blocks_in_use--;
                r.ok              = 1'b1;
            end
        end
        r.in_use = COUNT_W'(blocks_in_use);
        return r;
    endfunction

    // Mostly back-to-back, sometimes a short pause, rarely a long one.
    function automatic int pick_gap();
        int unsigned r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    task automatic queue_req(input t_kind kind, input logic [OFFSET_W-1:0] uoff);
        t_req_item item;
        item.kind        = kind;
        item.user_offset = uoff;
        pending_req_q.push_back(item);
    endtask

    task automatic wait_idle();
        while (pending_req_q.size() != 0 || req.valid || expected_rsp_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg.valid <= 1'b1;
        cfg.addr  <= idx;
        cfg.data  <= value;
        do @(posedge i_clk); while (!(cfg.valid && cfg.ready));
        cfg.valid <= 1'b0;
        pool_apply_config(idx, value);
        @(negedge i_clk);
    endtask

    // Frees target blocks that are allocated when the batch is built, so most of
    // them succeed; the rest are double frees, bad alignment and stray offsets.
    task automatic push_random_batch(input int n);
        int unsigned s;
        int unsigned cnt;
        int unsigned idx;
        int unsigned pick;
        int unsigned top_idx;
        int unsigned live [$];
        logic [OFFSET_W-1:0] freed [$];
        logic [OFFSET_W-1:0] off;
        s       = pool_stride();
        cnt     = pool_eff_count();
        top_idx = (OFFSET_MAX - HDR_BYTES) / s;
        for (int i = 0; i < cnt; i++) begin
            if (block_marked[i]) live.push_back(i);
        end
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 45 || (pick < 75 && live.size() == 0)) begin
                queue_req(KIND_ALLOC, OFFSET_W'($urandom));
            end else if (pick < 75) begin
                idx = $urandom_range(0, live.size() - 1);
                off = OFFSET_W'(live[idx] * s + HDR_BYTES);
                live.delete(idx);
                freed.push_back(off);
                queue_req(KIND_FREE, off);
            end else if (pick < 83) begin
                if (freed.size() != 0 && $urandom_range(0, 1) == 1) begin
                    off = freed[$urandom_range(0, freed.size() - 1)];
                end else begin
                    idx = $urandom_range(0, (cnt == 0) ? 0 : cnt - 1);
                    off = OFFSET_W'(idx * s + HDR_BYTES);
                end
                queue_req(KIND_FREE, off);
            end else if (pick < 89) begin
                idx = (cnt <= top_idx) ? $urandom_range(cnt, top_idx) : top_idx;
                queue_req(KIND_FREE, OFFSET_W'(idx * s + HDR_BYTES));
            end else if (pick < 95) begin
                if ($urandom_range(0, 3) == 0) begin
                    off = OFFSET_W'($urandom_range(0, HDR_BYTES - 1));
                end else begin
                    idx = $urandom_range(0, top_idx);
                    off = OFFSET_W'(idx * s + HDR_BYTES + $urandom_range(1, s - 1));
                end
                queue_req(KIND_FREE, off);
            end else begin
                queue_req(KIND_FREE, OFFSET_W'($urandom));
            end
        end
        random_items_sent += n;
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req.valid     <= 1'b0;
            send_gap_left = 0;
        end else begin
            if (req.valid && req.ready) begin
                expected_rsp_q.push_back(pool_apply_request(req.kind, req.user_offset));
                void'(pending_req_q.pop_front());
                send_gap_left = pick_gap();
            end
            if (req.valid && !req.ready) begin
                // Keep offering the same item until it is taken.
            end else if (send_gap_left > 0) begin
                send_gap_left--;
                req.valid <= 1'b0;
            end else if (pending_req_q.size() != 0) begin
                req.valid       <= 1'b1;
                req.kind        <= pending_req_q[0].kind;
                req.user_offset <= pending_req_q[0].user_offset;
            end else begin
                req.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, started on request from the stimulus sequence.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left   <= 0;
            hold_served <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end
    end

    // Response monitor and checker.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp.ready       <= 1'b0;
            recv_stall_left = 0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                if (expected_rsp_q.size() == 0) begin
                    log_failure($sformatf("cycle %0d: result with no request outstanding",
                                          cycle_count));
                end else begin
                    rsp_want = expected_rsp_q.pop_front();
                    if (rsp.ok !== rsp_want.ok || rsp.error !== rsp_want.error ||
                        rsp.alloc_offset !== rsp_want.alloc_offset ||
                        rsp.in_use !== rsp_want.in_use) begin
                        log_failure($sformatf(
                            "cycle %0d: expected ok=%0d err=%0d off=%0d use=%0d, got %0d %0d %0d %0d",
                            cycle_count, rsp_want.ok, rsp_want.error, rsp_want.alloc_offset,
                            rsp_want.in_use, rsp.ok, rsp.error, rsp.alloc_offset, rsp.in_use));
                    end
                end
                recv_stall_left = pick_gap();
            end
            if (hold_left > 0) begin
                rsp.ready <= 1'b0;
            end else if (recv_stall_left > 0) begin
                recv_stall_left--;
                rsp.ready <= 1'b0;
            end else begin
                rsp.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] payload_set [NUM_SETTINGS];
        logic [CFG_DATA_W-1:0] count_set [NUM_SETTINGS];
        int setting;
        int target;

        // The writes with high bits set check that only the register width is kept.
        payload_set = '{16'd0, 16'd4096, 16'hFFFF, 16'd13, 16'd1, 16'd100, 16'd60, 16'd7};
        count_set   = '{16'd1, 16'd8, 16'hFE05, 16'd16, 16'd2, 16'd37, 16'd300, 16'd12};

        i_rst_n         = 1'b0;
        req.valid       = 1'b0;
        req.kind        = KIND_ALLOC;
        req.user_offset = '0;
        cfg.valid       = 1'b0;
        cfg.addr        = REG_PAYLOAD;
        cfg.data        = '0;
        rsp.ready       = 1'b0;
        fail_count      = 0;
        cycle_count     = 0;
        hold_asked      = 0;
        no_idle         = 1'b0;
        pressure_done   = 1'b0;
        random_items_sent = 0;
        payload_cfg     = RESET_PAYLOAD;
        count_cfg       = RESET_COUNT;
        pool_rebuild();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: stride 64, 256 blocks.
        queue_req(KIND_ALLOC, '0);
        queue_req(KIND_ALLOC, '1);
        queue_req(KIND_FREE, 21'd68);
        queue_req(KIND_FREE, 21'd68);
        queue_req(KIND_FREE, 21'd0);
        queue_req(KIND_FREE, 21'd3);
        queue_req(KIND_FREE, 21'd5);
        queue_req(KIND_FREE, 21'd16388);
        queue_req(KIND_FREE, '1);
        queue_req(KIND_FREE, 21'd2097092);
        queue_req(KIND_FREE, 21'd132);
        queue_req(KIND_ALLOC, '0);
        wait_idle();

        // Writes past the register list must leave the pool as it is.
        write_reg(REG_UNUSED_HI, 16'h0005);
        write_reg(REG_UNUSED_LO, 16'hFFFF);
        queue_req(KIND_ALLOC, '0);
        queue_req(KIND_FREE, 21'd4);
        wait_idle();

        // Zero payload, three blocks: run the pool dry, then reuse the freed one.
        write_reg(REG_PAYLOAD, 16'd0);
        write_reg(REG_COUNT, 16'd3);
        repeat (4) queue_req(KIND_ALLOC, '0);
        queue_req(KIND_FREE, 21'd8);
        queue_req(KIND_ALLOC, '0);
        wait_idle();

        write_reg(REG_COUNT, 16'd0);
        queue_req(KIND_ALLOC, '0);
        queue_req(KIND_FREE, 21'd4);
        queue_req(KIND_FREE, 21'd6);
        wait_idle();

        // Largest payload with a count that saturates.
        write_reg(REG_PAYLOAD, 16'd8191);
        write_reg(REG_COUNT, 16'd300);
        queue_req(KIND_FREE, 21'd2089984);
        queue_req(KIND_ALLOC, '0);
        wait_idle();

        setting = 0;
        while (random_items_sent < RANDOM_ITEMS) begin
            write_reg(REG_PAYLOAD, payload_set[setting % NUM_SETTINGS]);
            write_reg(REG_COUNT, count_set[setting % NUM_SETTINGS]);
            target = random_items_sent + PHASE_ITEMS;
            if (setting % NUM_SETTINGS == 3 && !pressure_done) begin
                // Stall the output while items keep coming, so the input backs up.
                no_idle = 1'b1;
                hold_asked++;
                push_random_batch(40);
                wait_idle();
                pressure_done = 1'b1;
            end
            while (random_items_sent < target) begin
                no_idle = ($urandom_range(0, 4) == 0);
                push_random_batch($urandom_range(8, 24));
                wait_idle();
            end
            setting++;
        end
        no_idle = 1'b0;

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_rsp_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/fbpa_pkg.sv
rtl/fbpa_if.sv
rtl/fbpa_cfg.sv
rtl/fbpa_div.sv
rtl/fbpa_list.sv
rtl/fixed_block_pool_allocator.sv
rtl/fbpa_checker.sv
tb/tb.sv
